[rtl/core/pscfs_pkg.sv]
`default_nettype none

package pscfs_pkg;

	// field widths
	localparam int unsigned CMD_W = 2;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned RXID_W = 32;
	localparam int unsigned ID_W = 29;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned SPEED_W = 13;
	localparam int unsigned INTERVAL_W = 8;
	localparam int unsigned PERIOD_W = 8;
	localparam int unsigned LEAD_W = 8;
	localparam int unsigned ROLL_W = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_RISE = 2'd0,
		CMD_FALL = 2'd1,
		CMD_TICK = 2'd2,
		CMD_RXID = 2'd3
	} cmd_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE = 2'd2;

	localparam logic [INTERVAL_W-1:0] SEND_INTERVAL_RST = 8'd15;
	localparam logic [ID_W-1:0] TRIGGER_ID_RST = 29'h1B200002;
	localparam logic [PERIOD_W-1:0] KEEPALIVE_RST = 8'd30;

	// pulse width to speed scaling
	localparam int unsigned PULSE_W = 13;
	localparam logic [TIME_W-1:0] PULSE_FULL_US = 32'd4600;
	localparam int unsigned PROD_W = 26;
	localparam int unsigned RECIP_SHIFT = 39;
	localparam int unsigned RECIP_W = 27;
	// ceil(2^39 / 4600): exact floor division for any 26-bit dividend
	localparam logic [RECIP_W-1:0] PULSE_RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd4599) / 64'd4600);

	// frame layout
	localparam logic [ID_W-1:0] KEEPALIVE_ID = 29'h1AE0092C;
	localparam logic [ID_W-1:0] SPEED_ID = 29'h2104136;
	localparam logic [DATA_W-LEAD_W-1:0] KEEPALIVE_TAIL = 56'h0022E041900000;
	localparam logic [47:0] SPEED_HEAD = 48'hBB003FFF06E0;
	localparam logic RXID_EXT_BIT = 1'b1;

	typedef struct packed {
		logic [INTERVAL_W-1:0] send_interval_ms;
		logic [ID_W-1:0] trigger_id;
		logic [PERIOD_W-1:0] keepalive_period;
	} cfg_regs_t;

	// one transmission round handed from front to back
	typedef struct packed {
		logic [SPEED_W-1:0] speed;
	} round_req_t;

	typedef enum logic {
		BK_FIRST = 1'b0,
		BK_SPEED = 1'b1
	} back_state_t;

	function automatic logic [LEAD_W-1:0] lead_entry(input logic [ROLL_W-1:0] idx);
		logic [LEAD_W-1:0] v;
		case (idx)
			2'd0: v = 8'h00;
			2'd1: v = 8'h40;
			2'd2: v = 8'h80;
			2'd3: v = 8'hC0;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/core/pscfs_in_if.sv]
`default_nettype none

interface pscfs_in_if import pscfs_pkg::*; ();
	logic valid;
	logic ready;
	logic [CMD_W-1:0] cmd;
	logic [TIME_W-1:0] time_value;
	logic [RXID_W-1:0] rx_id;

	modport source (output valid, output cmd, output time_value, output rx_id, input ready);
	modport sink (input valid, input cmd, input time_value, input rx_id, output ready);
endinterface

`default_nettype wire

[rtl/core/pscfs_out_if.sv]
`default_nettype none

interface pscfs_out_if import pscfs_pkg::*; ();
	logic valid;
	logic ready;
	logic [ID_W-1:0] frame_id;
	logic [DATA_W-1:0] frame_data;
	logic last_frame;

	modport source (output valid, output frame_id, output frame_data, output last_frame,
		input ready);
	modport sink (input valid, input frame_id, input frame_data, input last_frame,
		output ready);
endinterface

`default_nettype wire

[rtl/core/pscfs_cfg_if.sv]
`default_nettype none

interface pscfs_cfg_if import pscfs_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

[rtl/core/pwm_speed_can_frame_scheduler_unit.sv]
// throughput: one request per cycle while no round waits for queue space; a tick that
// sends a keep-alive frame occupies the frame output with both of its frames, set by the
// single output register of the back end; a two-entry round queue lets requests keep
// flowing while frames wait on the output
// reset: arst_n clears the control state and loads the register defaults, no clearing pass
`default_nettype none

module pwm_speed_can_frame_scheduler_unit import pscfs_pkg::*; #(
	parameter int unsigned SPEED_FULL_SCALE = 6000
) (
	input logic clk,
	input logic arst_n,
	pscfs_in_if.sink events,
	pscfs_out_if.source frames,
	pscfs_cfg_if.sink cfg
);

	cfg_regs_t regs_q;
	logic push, pop, full, empty;
	round_req_t push_req, head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.send_interval_ms <= SEND_INTERVAL_RST;
			regs_q.trigger_id <= TRIGGER_ID_RST;
			regs_q.keepalive_period <= KEEPALIVE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SEND_INTERVAL: regs_q.send_interval_ms <= cfg.wdata[INTERVAL_W-1:0];
				CFG_TRIGGER_ID: regs_q.trigger_id <= cfg.wdata[ID_W-1:0];
				CFG_KEEPALIVE: regs_q.keepalive_period <= cfg.wdata[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pscfs_front #(
		.SPEED_FULL_SCALE(SPEED_FULL_SCALE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.events(events),
		.regs(regs_q),
		.full(full),
		.push(push),
		.push_req(push_req)
	);

	pscfs_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_req(push_req),
		.pop(pop),
		.head(head),
		.full(full),
		.empty(empty)
	);

	pscfs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.keepalive_period(regs_q.keepalive_period),
		.head(head),
		.empty(empty),
		.pop(pop),
		.frames(frames)
	);

endmodule

`default_nettype wire

[rtl/core/pscfs_front.sv]
`default_nettype none

module pscfs_front import pscfs_pkg::*; #(
	parameter int unsigned SPEED_FULL_SCALE = 6000
) (
	input logic clk,
	input logic arst_n,
	pscfs_in_if.sink events,
	input cfg_regs_t regs,
	input logic full,
	output logic push,
	output round_req_t push_req
);

	localparam logic [SPEED_W-1:0] FULL = SPEED_W'(SPEED_FULL_SCALE);

	logic v_s1, v_s2, v_s3;
	cmd_t cmd_s1, cmd_s2, cmd_s3;
	logic [TIME_W-1:0] time_s1, time_s2, time_s3;
	logic match_s1, match_s2, match_s3;
	logic over_s1, over_s2, over_s3;
	logic [PULSE_W-1:0] width_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [SPEED_W-1:0] quot_s3;

	logic [TIME_W-1:0] rise_q;
	logic [SPEED_W-1:0] speed_q;
	logic tx_en_q;
	logic [TIME_W-1:0] last_send_q;

	logic [TIME_W-1:0] diff;
	logic [PROD_W+RECIP_W-1:0] scaled;
	logic [TIME_W-1:0] gap;
	logic send;
	logic adv;
	logic acc;

	assign diff = events.time_value - rise_q;
	assign scaled = {{RECIP_W{1'b0}}, prod_s2} * {{PROD_W{1'b0}}, PULSE_RECIP};
	assign gap = time_s3 - last_send_q;
	assign send = v_s3 && (cmd_s3 == CMD_TICK) && tx_en_q &&
		(gap >= {{(TIME_W-INTERVAL_W){1'b0}}, regs.send_interval_ms});

	// whole pipeline holds while a round waits for queue space
	assign adv = !(send && full);
	assign events.ready = adv;
	assign acc = events.valid && adv;

	assign push = send && !full;
	assign push_req.speed = speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			rise_q <= '0;
			speed_q <= '0;
			tx_en_q <= 1'b0;
			last_send_q <= '0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (acc && (cmd_t'(events.cmd) == CMD_RISE)) begin
				rise_q <= events.time_value;
			end
			if (v_s3) begin
				case (cmd_s3)
					CMD_FALL: begin
						speed_q <= over_s3 ? '0 : FULL - quot_s3;
					end
					CMD_RXID: begin
						if (match_s3) begin
							tx_en_q <= 1'b1;
						end
					end
					CMD_TICK: begin
						if (send) begin
							last_send_q <= time_s3;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_t'(events.cmd);
			time_s1 <= events.time_value;
			match_s1 <= (events.rx_id[RXID_W-1] == RXID_EXT_BIT) &&
				(events.rx_id[ID_W-1:0] == regs.trigger_id);
			over_s1 <= diff > PULSE_FULL_US;
			width_s1 <= diff[PULSE_W-1:0];

			cmd_s2 <= cmd_s1;
			time_s2 <= time_s1;
			match_s2 <= match_s1;
			over_s2 <= over_s1;
			prod_s2 <= {{(PROD_W-PULSE_W){1'b0}}, width_s1} *
				{{(PROD_W-SPEED_W){1'b0}}, FULL};

			cmd_s3 <= cmd_s2;
			time_s3 <= time_s2;
			match_s3 <= match_s2;
			over_s3 <= over_s2;
			quot_s3 <= scaled[RECIP_SHIFT +: SPEED_W];
		end
	end

endmodule

`default_nettype wire

[rtl/core/pscfs_fifo.sv]
`default_nettype none

module pscfs_fifo import pscfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input round_req_t push_req,
	input logic pop,
	output round_req_t head,
	output logic full,
	output logic empty
);

	round_req_t mem [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("request pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("request popped from empty queue");
`endif

endmodule

`default_nettype wire

[rtl/core/pscfs_back.sv]
`default_nettype none

module pscfs_back import pscfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [PERIOD_W-1:0] keepalive_period,
	input round_req_t head,
	input logic empty,
	output logic pop,
	pscfs_out_if.source frames
);

	back_state_t state_q, state_d;
	logic [PERIOD_W-1:0] round_q;
	logic [ROLL_W-1:0] roll_q;
	logic [LEAD_W-1:0] lead_q;

	logic out_v_q;
	logic [ID_W-1:0] id_q;
	logic [DATA_W-1:0] data_q;
	logic last_q;

	logic load;
	logic fire;
	logic emit_ka;
	logic [ID_W-1:0] id_d;
	logic [DATA_W-1:0] data_d;
	logic [PERIOD_W:0] round_inc;

	assign load = !out_v_q || frames.ready;
	assign fire = load && !empty;
	assign round_inc = {1'b0, round_q} + 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_FIRST: begin
				if (fire && (round_q == '0)) begin
					state_d = BK_SPEED;
				end
			end
			BK_SPEED: begin
				if (fire) begin
					state_d = BK_FIRST;
				end
			end
			default: state_d = BK_FIRST;
		endcase
	end

	always_comb begin
		emit_ka = 1'b0;
		case (state_q)
			BK_FIRST: emit_ka = round_q == '0;
			BK_SPEED: emit_ka = 1'b0;
			default: emit_ka = 1'b0;
		endcase
		pop = fire && !emit_ka;
		if (emit_ka) begin
			id_d = KEEPALIVE_ID;
			data_d = {lead_q, KEEPALIVE_TAIL};
		end else begin
			id_d = SPEED_ID;
			data_d = {SPEED_HEAD, {(16-SPEED_W){1'b0}}, head.speed};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_FIRST;
			round_q <= '0;
			roll_q <= '0;
			lead_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (frames.ready) begin
				out_v_q <= 1'b0;
			end
			if (fire && emit_ka) begin
				lead_q <= lead_entry(roll_q);
				roll_q <= roll_q + 1'b1;
			end
			if (pop) begin
				round_q <= (round_inc >= {1'b0, keepalive_period}) ? '0
					: round_inc[PERIOD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			id_q <= id_d;
			data_q <= data_d;
			last_q <= !emit_ka;
		end
	end

	assign frames.valid = out_v_q;
	assign frames.frame_id = id_q;
	assign frames.frame_data = data_q;
	assign frames.last_frame = last_q;

`ifndef SYNTHESIS
	a_ka_then_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit_ka) |=> (state_q == BK_SPEED))
		else $error("keep-alive frame not followed by speed frame");
	a_last_is_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (last_q == (id_q == SPEED_ID)))
		else $error("last flag does not match frame kind");
	a_second_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SPEED) |-> !empty)
		else $error("speed frame pending without queued round");
`endif

endmodule

`default_nettype wire
